>>> rtl/core/tfsp_pkg.sv
// tfsp_pkg: shared types, constants and steering helpers for the tape follow steering pid
// no dependencies; used by tfsp_datapath and tape_follow_steering_pid
package tfsp_pkg;

   // steering state, ordered from far negative to far positive
   typedef enum logic [2:0] {
      STEER_FAR_NEG = 3'd0,
      STEER_NEG     = 3'd1,
      STEER_CENTER  = 3'd2,
      STEER_POS     = 3'd3,
      STEER_FAR_POS = 3'd4
   } steer_type;

   // magnitude of the far steering value
   localparam int FAR_MAG = 5;

   // csr register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_GAIN   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SERVO_LOW    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SERVO_HIGH   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_SERVO_CENTER = 3'd6;

   // field widths
   localparam int GAIN_W   = 8;
   localparam int SERVO_W  = 12;
   localparam int INTEG_W  = 13;
   localparam int TERM_W   = 15;
   localparam int OVER_W   = 25;
   localparam int STEER_W  = 3;
   localparam int RSP_W    = 40;

   // reset values
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 8'd50;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 8'd50;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 8'd10;
   localparam logic [SERVO_W-1:0] INTEG_LIMIT_RST  = 12'd200;
   localparam logic [SERVO_W-1:0] SERVO_LOW_RST    = 12'd1700;
   localparam logic [SERVO_W-1:0] SERVO_HIGH_RST   = 12'd2600;
   localparam logic [SERVO_W-1:0] SERVO_CENTER_RST = 12'd2000;

   // live configuration seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [SERVO_W-1:0] integ_limit;
      logic [SERVO_W-1:0] servo_low;
      logic [SERVO_W-1:0] servo_high;
   } cfg_type;

   // signed steering value of a state
   function automatic logic signed [3:0] steer_value(input steer_type s);
      logic signed [3:0] far_val;
      far_val = 4'(FAR_MAG);
      case (s)
         STEER_FAR_NEG: steer_value = -far_val;
         STEER_NEG:     steer_value = -4'sd1;
         STEER_POS:     steer_value = 4'sd1;
         STEER_FAR_POS: steer_value = far_val;
         default:       steer_value = 4'sd0;
      endcase
   endfunction

   // steering transition on the eye pattern (r: right on, l: left on)
   function automatic steer_type next_steer(input steer_type s, input logic r, input logic l);
      next_steer = s;
      case (s)
         STEER_CENTER: begin
            if (r && !l) next_steer = STEER_NEG;
            else if (!r && l) next_steer = STEER_POS;
         end
         STEER_NEG: begin
            if (r && l) next_steer = STEER_CENTER;
            else if (!r && !l) next_steer = STEER_FAR_NEG;
         end
         STEER_POS: begin
            if (r && l) next_steer = STEER_CENTER;
            else if (!r && !l) next_steer = STEER_FAR_POS;
         end
         STEER_FAR_NEG: begin
            if (r && !l) next_steer = STEER_NEG;
         end
         STEER_FAR_POS: begin
            if (!r && l) next_steer = STEER_POS;
         end
         default: next_steer = STEER_CENTER;
      endcase
   endfunction

endpackage

>>> rtl/core/tfsp_datapath.sv
// tfsp_datapath: one-tick steering step, pid term, command saturation and servo clamp
// depends on tfsp_pkg
module tfsp_datapath #(
   parameter int SAMPLE_BITS = 12,
   parameter int ACC_BITS    = 24
) (
   input  logic [SAMPLE_BITS-1:0]           level_sample,
   input  logic [SAMPLE_BITS-1:0]           right_sample,
   input  logic [SAMPLE_BITS-1:0]           left_sample,
   input  tfsp_pkg::steer_type              steer_cur,
   input  logic signed [tfsp_pkg::INTEG_W-1:0] integ_cur,
   input  logic signed [ACC_BITS-1:0]       cmd_cur,
   input  tfsp_pkg::cfg_type                cfg,
   output tfsp_pkg::steer_type              steer_nxt,
   output logic signed [tfsp_pkg::INTEG_W-1:0] integ_nxt,
   output logic signed [ACC_BITS-1:0]       cmd_nxt,
   output logic [tfsp_pkg::SERVO_W-1:0]     servo_pulse,
   output logic signed [tfsp_pkg::OVER_W-1:0] overshoot
);

   localparam int IW  = tfsp_pkg::INTEG_W;
   localparam int TW  = tfsp_pkg::TERM_W;
   localparam int SW  = tfsp_pkg::SERVO_W;
   localparam int OW  = tfsp_pkg::OVER_W;
   localparam int CW  = ACC_BITS + 1;
   localparam int DW  = (CW > OW) ? CW : OW;

   logic                 eye_r, eye_l;
   logic signed [3:0]    sv, lv;
   logic signed [4:0]    dv;
   logic signed [IW-1:0] p_term, d_term, i_step;
   logic signed [IW:0]   acc_sum, lim_pos, lim_neg;
   logic signed [TW-1:0] term;
   logic signed [CW-1:0] cmd_sum;
   logic signed [DW-1:0] cmd_ext, hi_ext, lo_ext, over_full;

   always_comb begin
      eye_r = right_sample > level_sample;
      eye_l = left_sample > level_sample;
      steer_nxt = tfsp_pkg::next_steer(steer_cur, eye_r, eye_l);
      sv = tfsp_pkg::steer_value(steer_nxt);
      lv = tfsp_pkg::steer_value(steer_cur);
      dv = {sv[3], sv} - {lv[3], lv};

      // small gain products
      p_term = IW'($signed({1'b0, cfg.prop_gain})) * IW'(sv);
      d_term = IW'($signed({1'b0, cfg.deriv_gain})) * IW'(dv);
      i_step = IW'($signed({1'b0, cfg.integ_gain})) * IW'(sv);

      // held integral with symmetric clamp
      acc_sum = {integ_cur[IW-1], integ_cur} + {i_step[IW-1], i_step};
      lim_pos = $signed({2'b00, cfg.integ_limit});
      lim_neg = -lim_pos;
      if (acc_sum > lim_pos)      integ_nxt = lim_pos[IW-1:0];
      else if (acc_sum < lim_neg) integ_nxt = lim_neg[IW-1:0];
      else                        integ_nxt = acc_sum[IW-1:0];

      term = TW'(p_term) + TW'(d_term) + TW'(integ_nxt);

      // running command, saturated on signed overflow
      cmd_sum = {cmd_cur[ACC_BITS-1], cmd_cur} + CW'(term);
      if (cmd_sum[CW-1] != cmd_sum[CW-2])
         cmd_nxt = cmd_sum[CW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
      else
         cmd_nxt = cmd_sum[ACC_BITS-1:0];

      // servo clamp, upper limit tested first
      cmd_ext = DW'(cmd_nxt);
      hi_ext  = $signed({{(DW-SW){1'b0}}, cfg.servo_high});
      lo_ext  = $signed({{(DW-SW){1'b0}}, cfg.servo_low});
      if (cmd_ext > hi_ext) begin
         over_full   = cmd_ext - hi_ext;
         servo_pulse = cfg.servo_high;
      end else if (cmd_ext < lo_ext) begin
         over_full   = cmd_ext - lo_ext;
         servo_pulse = cfg.servo_low;
      end else begin
         over_full   = '0;
         servo_pulse = cmd_nxt[SW-1:0];
      end
      overshoot = over_full[OW-1:0];
   end

endmodule

>>> rtl/core/tape_follow_steering_pid.sv
// tape_follow_steering_pid: top level, request/response stream wrapper and csr bank
// depends on tfsp_pkg and tfsp_datapath
//
// a request passes the input register and then the result register before its response
// throughput: 1 request per cycle while responses drain; the step sits between the two registers
// the response register parts the two sides, so a request is taken while a result waits
// reset: synchronous active-high; steering to center, integral to 0, command to 2000,
// all csr registers back to their defaults
module tape_follow_steering_pid #(
   parameter int SAMPLE_BITS = 12,
   parameter int ACC_BITS    = 24
) (
   input  logic clock,
   input  logic reset,

   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: level_sample, right_sample, left_sample, zero pad to bytes
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,

   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // fields from bit 0: servo_pulse[11:0], overshoot[24:0], steer_code[2:0]
   output logic [tfsp_pkg::RSP_W-1:0]            rsp_tdata,

   // csr write port
   input  logic                                  csr_we,
   input  logic [tfsp_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [tfsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int REQ_FW = 3 * SAMPLE_BITS;
   localparam int IW     = tfsp_pkg::INTEG_W;

   // csr bank
   tfsp_pkg::cfg_type cfg_ff, cfg_in;

   // request stage
   logic              req_valid_ff, req_valid_in;
   logic [REQ_FW-1:0] req_data_ff, req_data_in;

   // loop state carried from tick to tick
   tfsp_pkg::steer_type         steer_ff, steer_in;
   logic signed [IW-1:0]        integ_ff, integ_in;
   logic signed [ACC_BITS-1:0]  cmd_ff, cmd_in;

   // response stage
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tfsp_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // datapath results
   tfsp_pkg::steer_type              dp_steer;
   logic signed [IW-1:0]             dp_integ;
   logic signed [ACC_BITS-1:0]       dp_cmd;
   logic [tfsp_pkg::SERVO_W-1:0]     dp_servo;
   logic signed [tfsp_pkg::OVER_W-1:0] dp_over;

   logic advance;

   // request stage moves into the result register when that register is free or drains
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tfsp_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_datapath (
      .level_sample (req_data_ff[SAMPLE_BITS-1:0]),
      .right_sample (req_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .left_sample  (req_data_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .steer_cur    (steer_ff),
      .integ_cur    (integ_ff),
      .cmd_cur      (cmd_ff),
      .cfg          (cfg_ff),
      .steer_nxt    (dp_steer),
      .integ_nxt    (dp_integ),
      .cmd_nxt      (dp_cmd),
      .servo_pulse  (dp_servo),
      .overshoot    (dp_over)
   );

   // csr writes; the center value only matters at reset, which always uses its fixed
   // default, so a write to it changes nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            tfsp_pkg::CSR_PROP_GAIN:   cfg_in.prop_gain   = csr_wdata[tfsp_pkg::GAIN_W-1:0];
            tfsp_pkg::CSR_DERIV_GAIN:  cfg_in.deriv_gain  = csr_wdata[tfsp_pkg::GAIN_W-1:0];
            tfsp_pkg::CSR_INTEG_GAIN:  cfg_in.integ_gain  = csr_wdata[tfsp_pkg::GAIN_W-1:0];
            tfsp_pkg::CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata;
            tfsp_pkg::CSR_SERVO_LOW:   cfg_in.servo_low   = csr_wdata;
            tfsp_pkg::CSR_SERVO_HIGH:  cfg_in.servo_high  = csr_wdata;
            tfsp_pkg::CSR_SERVO_CENTER: cfg_in = cfg_ff;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // next values of the pipeline and loop state
   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      steer_in     = steer_ff;
      integ_in     = integ_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      // a tick commits its state together with its result
      if (advance) begin
         steer_in     = dp_steer;
         integ_in     = dp_integ;
         cmd_in       = dp_cmd;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {dp_steer, dp_over, dp_servo};
         req_valid_in = 1'b0;
      end

      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
         req_data_in  = req_tdata[REQ_FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= tfsp_pkg::PROP_GAIN_RST;
         cfg_ff.deriv_gain  <= tfsp_pkg::DERIV_GAIN_RST;
         cfg_ff.integ_gain  <= tfsp_pkg::INTEG_GAIN_RST;
         cfg_ff.integ_limit <= tfsp_pkg::INTEG_LIMIT_RST;
         cfg_ff.servo_low   <= tfsp_pkg::SERVO_LOW_RST;
         cfg_ff.servo_high  <= tfsp_pkg::SERVO_HIGH_RST;
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         steer_ff           <= tfsp_pkg::STEER_CENTER;
         integ_ff           <= '0;
         cmd_ff             <= ACC_BITS'(tfsp_pkg::SERVO_CENTER_RST);
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         steer_ff     <= steer_in;
         integ_ff     <= integ_in;
         cmd_ff       <= cmd_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a held request means the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !req_tready) |-> (rsp_valid_ff && !rsp_tready))
      else $error("request stage stalled without a stalled response");

   // every committed tick shows up as a response
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("committed tick produced no response");

   // far negative only ever leaves toward negative
   a_far_neg_exit: assert property (@(posedge clock) disable iff (reset)
      (advance && steer_ff == tfsp_pkg::STEER_FAR_NEG) |=>
      (steer_ff == tfsp_pkg::STEER_FAR_NEG || steer_ff == tfsp_pkg::STEER_NEG))
      else $error("illegal steering move out of far negative");

endmodule
